FILE: sv/dwpi_pkg.sv
// ============================================================================
// dwpi_pkg
// Shared widths, reset values, register indexes and control types of the
// dual-wheel incremental PI drive block.
// ============================================================================
package dwpi_pkg;

  localparam int TGT_W     = 11;
  localparam int CNT_W     = 15;
  localparam int GAIN_W    = 16;
  localparam int DMAX_W    = 10;
  localparam int DMIN_W    = 11;
  localparam int HOLD_W    = 8;
  localparam int RAMP_W    = 8;
  localparam int FWD_W     = 10;
  localparam int REV_W     = 11;
  localparam int ACC_W     = 11;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 18;
  localparam int INC_W     = 28;

  // Ramp scaling is a multiply by a pre-scaled reciprocal. The scaled
  // product |acc| * ramp stays below 2^18, so a 26-bit shift is exact.
  localparam int SCALE_SHIFT = 26;
  localparam int RSCALE_W    = 27;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_HOLD = 3'd4;

  localparam logic [GAIN_W-1:0]        GAIN_P_RST    = 16'd973;
  localparam logic [GAIN_W-1:0]        GAIN_I_RST    = 16'd3200;
  localparam logic [DMAX_W-1:0]        DRIVE_MAX_RST = 10'd990;
  localparam logic signed [DMIN_W-1:0] DRIVE_MIN_RST = -11'sd200;
  localparam logic [HOLD_W-1:0]        STOP_HOLD_RST = 8'd100;

  // Load strobes that move a word through the lane pipelines.
  typedef struct packed {
    logic accept;  // word taken from the input channel
    logic ld_b;    // product stage loads
    logic ld_c;    // increment stage loads
    logic upd;     // a real word enters the output stage
  } pipe_ctl_t;

endpackage

FILE: sv/dwpi_if.sv
// ============================================================================
// dwpi_in_if / dwpi_out_if
// Valid/ready channels carrying one tick word in and one duty word out.
// ============================================================================
interface dwpi_in_if;
  import dwpi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TGT_W-1:0] left_target;
  logic signed [TGT_W-1:0] right_target;
  logic [CNT_W-1:0]        left_count;
  logic                    left_dir;
  logic [CNT_W-1:0]        right_count;
  logic                    right_dir;
  logic [RAMP_W-1:0]       ramp_step;
  logic                    stop_request;

  modport source (output valid, left_target, right_target, left_count, left_dir,
                  right_count, right_dir, ramp_step, stop_request, input ready);
  modport sink (input valid, left_target, right_target, left_count, left_dir,
                right_count, right_dir, ramp_step, stop_request, output ready);
endinterface

interface dwpi_out_if;
  import dwpi_pkg::*;

  logic             valid;
  logic             ready;
  logic [FWD_W-1:0] left_fwd_duty;
  logic [REV_W-1:0] left_rev_duty;
  logic [FWD_W-1:0] right_fwd_duty;
  logic [REV_W-1:0] right_rev_duty;
  logic             stopped;

  modport source (output valid, left_fwd_duty, left_rev_duty, right_fwd_duty,
                  right_rev_duty, stopped, input ready);
  modport sink (input valid, left_fwd_duty, left_rev_duty, right_fwd_duty,
                right_rev_duty, stopped, output ready);
endinterface

FILE: sv/dwpi_lane.sv
// ============================================================================
// dwpi_lane
// One drive: error, incremental PI increment, clamped and ramped accumulator.
// ============================================================================
module dwpi_lane
  import dwpi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  pipe_ctl_t                ctl,
  input  logic signed [TGT_W-1:0]  target,
  input  logic [CNT_W-1:0]         count,
  input  logic                     count_pos,
  input  logic [GAIN_W-1:0]        gain_p,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic [DMAX_W-1:0]        drive_max,
  input  logic signed [DMIN_W-1:0] drive_min,
  input  logic [RSCALE_W-1:0]      rscale,
  input  logic                     scale_en,
  output logic [FWD_W-1:0]         fwd_duty,
  output logic [REV_W-1:0]         rev_duty
);

  localparam int SUM_W = 36;
  localparam int T_W   = 29;
  localparam int SP_W  = ACC_W + RSCALE_W;

  logic signed [ERR_W-1:0]  count_s;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [ERR_W-1:0]  err_a_r;
  logic signed [DIFF_W-1:0] diff_a_r;
  logic signed [34:0]       prod_p_r;
  logic signed [33:0]       prod_i_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_b;
  logic signed [INC_W-1:0]  inc_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [T_W-1:0]    t_sum;
  logic signed [T_W-1:0]    t_lo;
  logic signed [T_W-1:0]    t_hi;
  logic signed [T_W-1:0]    t_clamp;
  logic signed [ACC_W-1:0]  clamped;
  logic [ACC_W-1:0]         mag;
  logic [SP_W-1:0]          scl_prod;
  logic [ACC_W-1:0]         quo;
  logic signed [ACC_W-1:0]  scaled;

  // Input stage: signed count, error and error difference.
  always_comb begin
    count_s = count_pos ? $signed({2'b00, count}) : -$signed({2'b00, count});
    err     = $signed({{(ERR_W-TGT_W){target[TGT_W-1]}}, target}) - count_s;
    diff    = $signed({err[ERR_W-1], err}) - $signed({prev_err_r[ERR_W-1], prev_err_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (ctl.accept) begin
      prev_err_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      err_a_r  <= err;
      diff_a_r <= diff;
    end
    if (ctl.ld_b) begin
      prod_p_r <= $signed({1'b0, gain_p}) * diff_a_r;
      prod_i_r <= $signed({1'b0, gain_i}) * err_a_r;
    end
    if (ctl.ld_c) begin
      inc_r <= sum_b[SUM_W-1:8];
    end
  end

  // Sum of both terms, divided by 256 with truncation toward zero.
  always_comb begin
    sum   = $signed({prod_p_r[34], prod_p_r}) + $signed({{2{prod_i_r[33]}}, prod_i_r});
    sum_b = sum + (sum[SUM_W-1] ? 36'sd255 : 36'sd0);
  end

  // Accumulator loop: add, clamp low then high, optional ramp scaling.
  always_comb begin
    t_sum = $signed({{(T_W-ACC_W){acc_r[ACC_W-1]}}, acc_r})
          + $signed({inc_r[INC_W-1], inc_r});
    t_lo  = $signed({{(T_W-DMIN_W){drive_min[DMIN_W-1]}}, drive_min});
    t_hi  = $signed({{(T_W-DMAX_W){1'b0}}, drive_max});
    t_clamp = t_sum;
    if (t_clamp < t_lo) begin
      t_clamp = t_lo;
    end
    if (t_clamp > t_hi) begin
      t_clamp = t_hi;
    end
    clamped  = t_clamp[ACC_W-1:0];
    mag      = clamped[ACC_W-1] ? (~clamped + 11'd1) : clamped;
    scl_prod = {{RSCALE_W{1'b0}}, mag} * {{ACC_W{1'b0}}, rscale};
    quo      = scl_prod[SCALE_SHIFT+ACC_W-1:SCALE_SHIFT];
    scaled   = clamped[ACC_W-1] ? $signed(~quo + 11'd1) : $signed(quo);
    acc_nxt  = scale_en ? scaled : clamped;
    fwd_duty = acc_nxt[ACC_W-1] ? '0 : acc_nxt[FWD_W-1:0];
    rev_duty = acc_nxt[ACC_W-1] ? (~acc_nxt + 11'd1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.upd) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

FILE: sv/dwpi_stop.sv
// ============================================================================
// dwpi_stop
// Counts requested stop ticks and sets the stop latch after the hold count.
// ============================================================================
module dwpi_stop
  import dwpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              req,
  input  logic [HOLD_W-1:0] stop_hold,
  output logic              item_latched
);

  logic [HOLD_W-1:0] ticks_r;
  logic [HOLD_W-1:0] ticks_nxt;
  logic              lat_r;
  logic              lat_nxt;

  always_comb begin
    ticks_nxt = ticks_r;
    lat_nxt   = lat_r;
    if (!lat_r && req) begin
      ticks_nxt = ticks_r + 8'd1;
      lat_nxt   = (ticks_nxt >= stop_hold);
    end
  end

  assign item_latched = lat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= '0;
      lat_r   <= 1'b0;
    end else if (accept) begin
      ticks_r <= ticks_nxt;
      lat_r   <= lat_nxt;
    end
  end

  // The latch clears only on reset.
  a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
    lat_r |=> lat_r)
    else $error("stop latch cleared without reset");

  // Once latched, the tick counter no longer moves.
  a_ticks_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    lat_r |=> $stable(ticks_r))
    else $error("stop tick counter moved after latch");

endmodule

FILE: sv/dual_wheel_incremental_pi_pwm.sv
// ============================================================================
// dual_wheel_incremental_pi_pwm
// Two-lane incremental PI wheel speed controller with forward/reverse duties.
// ============================================================================
// Each input word is one control tick: two wheel targets, two encoder counts
// with direction bits, a soft-start ramp step and a stop request. Each output
// word carries the forward and reverse PWM duties of both drives and the stop
// flag. Both channels use valid/ready; a word moves when both are high.
// The right drive is fed by the left wheel error and the left drive by the
// right wheel error, each in its own lane.
// A word is registered at acceptance, then in the product, increment and
// output stages in turn. Throughput is one word per cycle while the receiver
// takes words; the limiting loop is the accumulator update (add, clamp, one
// narrow ramp multiply) in the output stage. The pipeline is four registered
// stages with a ready chain, so while the receiver stalls the block keeps
// accepting words until every stage is full; nothing is dropped or repeated.
// The user writes configuration through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block does not enforce this. Reset (synchronous,
// rst_n low) clears both accumulators, the previous errors, the stop counter
// and latch, empties the pipeline and restores the default gains and limits.
// ============================================================================
module dual_wheel_incremental_pi_pwm
  import dwpi_pkg::*;
#(
  parameter int RAMP_FULL = 100
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dwpi_in_if.sink              in_ch,
  dwpi_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Reciprocal of the ramp full scale, rounded up; exact for |acc| * ramp
  // below 2^18 with a 26-bit shift.
  localparam logic [RSCALE_W-1:0] RECIP =
    RSCALE_W'((2**SCALE_SHIFT + RAMP_FULL - 1) / RAMP_FULL);
  localparam logic [RAMP_W-1:0] RAMP_LIM = RAMP_W'(RAMP_FULL);

  // Configuration registers.
  logic [GAIN_W-1:0]        gain_p_r;
  logic [GAIN_W-1:0]        gain_i_r;
  logic [DMAX_W-1:0]        drive_max_r;
  logic signed [DMIN_W-1:0] drive_min_r;
  logic [HOLD_W-1:0]        stop_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      drive_max_r <= DRIVE_MAX_RST;
      drive_min_r <= DRIVE_MIN_RST;
      stop_hold_r <= STOP_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_P:    gain_p_r    <= cfg_data;
        CFG_GAIN_I:    gain_i_r    <= cfg_data;
        CFG_DRIVE_MAX: drive_max_r <= cfg_data[DMAX_W-1:0];
        CFG_DRIVE_MIN: drive_min_r <= $signed(cfg_data[DMIN_W-1:0]);
        CFG_STOP_HOLD: stop_hold_r <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline occupancy and the ready chain, from the output back.
  logic      v_a_r, v_b_r, v_c_r, v_o_r;
  logic      rdy_a, rdy_b, rdy_c, rdy_o;
  logic      accept;
  pipe_ctl_t ctl;

  assign rdy_o  = !v_o_r || out_ch.ready;
  assign rdy_c  = !v_c_r || rdy_o;
  assign rdy_b  = !v_b_r || rdy_c;
  assign rdy_a  = !v_a_r || rdy_b;
  assign in_ch.ready = rdy_a;
  assign accept = in_ch.valid && rdy_a;

  always_comb begin
    ctl.accept = accept;
    ctl.ld_b   = rdy_b;
    ctl.ld_c   = rdy_c;
    ctl.upd    = rdy_o && v_c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_o_r <= 1'b0;
    end else begin
      if (accept) begin
        v_a_r <= 1'b1;
      end else if (rdy_b) begin
        v_a_r <= 1'b0;
      end
      if (rdy_b) begin
        v_b_r <= v_a_r;
      end
      if (rdy_c) begin
        v_c_r <= v_b_r;
      end
      if (rdy_o) begin
        v_o_r <= v_c_r;
      end
    end
  end

  // Stop logic runs at acceptance; its verdict travels with the word.
  logic item_latched;

  dwpi_stop u_stop (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .req          (in_ch.stop_request),
    .stop_hold    (stop_hold_r),
    .item_latched (item_latched)
  );

  // Word-level side data: stop flag, scaling enable and the ramp factor
  // pre-multiplied by the reciprocal, carried alongside the lanes.
  logic [RSCALE_W-1:0] rscale_a_r, rscale_b_r, rscale_c_r;
  logic                sen_a_r, sen_b_r, sen_c_r;
  logic                lat_a_r, lat_b_r, lat_c_r;
  logic [RSCALE_W+RAMP_W-1:0] rscale_full;

  assign rscale_full = {{RAMP_W{1'b0}}, RECIP} * {{RSCALE_W{1'b0}}, in_ch.ramp_step};

  always_ff @(posedge clk) begin
    if (accept) begin
      rscale_a_r <= rscale_full[RSCALE_W-1:0];
      sen_a_r    <= !item_latched && (in_ch.ramp_step <= RAMP_LIM);
      lat_a_r    <= item_latched;
    end
    if (rdy_b) begin
      rscale_b_r <= rscale_a_r;
      sen_b_r    <= sen_a_r;
      lat_b_r    <= lat_a_r;
    end
    if (rdy_c) begin
      rscale_c_r <= rscale_b_r;
      sen_c_r    <= sen_b_r;
      lat_c_r    <= lat_b_r;
    end
  end

  // Right drive takes the left wheel error; left drive the right wheel error.
  logic [FWD_W-1:0] rd_fwd, ld_fwd;
  logic [REV_W-1:0] rd_rev, ld_rev;

  dwpi_lane u_lane_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .target    (in_ch.left_target),
    .count     (in_ch.left_count),
    .count_pos (in_ch.left_dir),
    .gain_p    (gain_p_r),
    .gain_i    (gain_i_r),
    .drive_max (drive_max_r),
    .drive_min (drive_min_r),
    .rscale    (rscale_c_r),
    .scale_en  (sen_c_r),
    .fwd_duty  (rd_fwd),
    .rev_duty  (rd_rev)
  );

  dwpi_lane u_lane_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .target    (in_ch.right_target),
    .count     (in_ch.right_count),
    .count_pos (!in_ch.right_dir),
    .gain_p    (gain_p_r),
    .gain_i    (gain_i_r),
    .drive_max (drive_max_r),
    .drive_min (drive_min_r),
    .rscale    (rscale_c_r),
    .scale_en  (sen_c_r),
    .fwd_duty  (ld_fwd),
    .rev_duty  (ld_rev)
  );

  // Merge stage: both lanes and the stop flag into the output register.
  // A latched stop forces every duty to zero.
  logic [FWD_W-1:0] lf_r, rf_r;
  logic [REV_W-1:0] lr_r, rr_r;
  logic             stopped_r;

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      lf_r      <= lat_c_r ? '0 : ld_fwd;
      lr_r      <= lat_c_r ? '0 : ld_rev;
      rf_r      <= lat_c_r ? '0 : rd_fwd;
      rr_r      <= lat_c_r ? '0 : rd_rev;
      stopped_r <= lat_c_r;
    end
  end

  assign out_ch.valid          = v_o_r;
  assign out_ch.left_fwd_duty  = lf_r;
  assign out_ch.left_rev_duty  = lr_r;
  assign out_ch.right_fwd_duty = rf_r;
  assign out_ch.right_rev_duty = rr_r;
  assign out_ch.stopped        = stopped_r;

  // A stopped word carries zero duties.
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v_o_r && stopped_r) |-> (lf_r == '0 && lr_r == '0 && rf_r == '0 && rr_r == '0))
    else $error("duty non-zero while stopped");

  // A drive never asks for forward and reverse at once.
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    v_o_r |-> ((lf_r == '0 || lr_r == '0) && (rf_r == '0 || rr_r == '0)))
    else $error("forward and reverse duty both active");

  // Input is refused only when every stage holds a word.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v_a_r && v_b_r && v_c_r && v_o_r))
    else $error("input stalled with a free pipeline stage");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_o_r && !out_ch.ready) |=> (v_o_r && $stable(lf_r) && $stable(rr_r)))
    else $error("output word changed while stalled");

endmodule

FILE: verif/dwpi_duty_check_pkg.sv
// ============================================================================
// dwpi_duty_check_pkg
// Word types and the duty scoreboard for the dual-wheel PI drive testbench.
// The scoreboard keeps its own copy of the gains, limits, accumulators and
// stop latch, works out the duty word owed for every accepted tick word and
// compares each duty word that leaves the block with the oldest one owed.
// ============================================================================
package dwpi_duty_check_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import dwpi_pkg::*;

  localparam int DRIVE_RAMP_FULL = 100;

  typedef struct packed {
    logic signed [TGT_W-1:0] left_target;
    logic signed [TGT_W-1:0] right_target;
    logic [CNT_W-1:0]        left_count;
    logic                    left_dir;
    logic [CNT_W-1:0]        right_count;
    logic                    right_dir;
    logic [RAMP_W-1:0]       ramp_step;
    logic                    stop_request;
  } tick_t;

  typedef struct packed {
    logic [FWD_W-1:0] left_fwd_duty;
    logic [REV_W-1:0] left_rev_duty;
    logic [FWD_W-1:0] right_fwd_duty;
    logic [REV_W-1:0] right_rev_duty;
    logic             stopped;
  } duty_t;

  class wheel_duty_scoreboard;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_i;
    logic [DMAX_W-1:0]        drive_max;
    logic signed [DMIN_W-1:0] drive_min;
    logic [HOLD_W-1:0]        stop_hold;

    logic signed [ACC_W-1:0]  acc_left;
    logic signed [ACC_W-1:0]  acc_right;
    logic signed [ERR_W-1:0]  last_left_err;
    logic signed [ERR_W-1:0]  last_right_err;
    logic [HOLD_W-1:0]        stop_ticks;
    logic                     stop_latched;

    duty_t                    owed_duties[$];
    int unsigned              errors;

    function new();
      gain_p         = GAIN_P_RST;
      gain_i         = GAIN_I_RST;
      drive_max      = DRIVE_MAX_RST;
      drive_min      = DRIVE_MIN_RST;
      stop_hold      = STOP_HOLD_RST;
      acc_left       = '0;
      acc_right      = '0;
      last_left_err  = '0;
      last_right_err = '0;
      stop_ticks     = '0;
      stop_latched   = 1'b0;
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_GAIN_P:    gain_p    = val[GAIN_W-1:0];
        CFG_GAIN_I:    gain_i    = val[GAIN_W-1:0];
        CFG_DRIVE_MAX: drive_max = val[DMAX_W-1:0];
        CFG_DRIVE_MIN: drive_min = val[DMIN_W-1:0];
        CFG_STOP_HOLD: stop_hold = val[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_duties.size();
    endfunction

    // Incremental PI step: the Q8 increment is truncated toward zero, then
    // the lower limit is applied before the upper one.
    function longint pi_update(longint acc, longint err, longint prev);
      longint kp;
      longint ki;
      longint lo;
      longint hi;
      longint sum;
      kp  = gain_p;
      ki  = gain_i;
      lo  = drive_min;
      hi  = drive_max;
      sum = kp * (err - prev) + ki * err;
      acc = acc + sum / 256;
      if (acc < lo) acc = lo;
      if (acc > hi) acc = hi;
      return acc;
    endfunction

    function void split_drive(logic signed [ACC_W-1:0] acc, output logic [FWD_W-1:0] fwd,
                              output logic [REV_W-1:0] rev);
      longint a;
      a = acc;
      if (a >= 0) begin
        fwd = FWD_W'(a);
        rev = '0;
      end else begin
        fwd = '0;
        rev = REV_W'(-a);
      end
    endfunction

    function void note_tick(tick_t t);
      longint l_cnt;
      longint r_cnt;
      longint l_err;
      longint r_err;
      longint ramp;
      longint scaled;
      duty_t  d;
      l_cnt = t.left_count;
      r_cnt = t.right_count;
      if (!t.left_dir) l_cnt = -l_cnt;
      if (t.right_dir) r_cnt = -r_cnt;
      l_err = longint'($signed(t.left_target)) - l_cnt;
      r_err = longint'($signed(t.right_target)) - r_cnt;

      // The drives are cross-fed: the right one integrates the left error.
      acc_right      = ACC_W'(pi_update(acc_right, l_err, last_left_err));
      acc_left       = ACC_W'(pi_update(acc_left, r_err, last_right_err));
      last_left_err  = ERR_W'(l_err);
      last_right_err = ERR_W'(r_err);

      if (!stop_latched && t.stop_request) begin
        stop_ticks = stop_ticks + 1'b1;
        if (stop_ticks >= stop_hold) stop_latched = 1'b1;
      end

      d = '0;
      d.stopped = stop_latched;
      if (!stop_latched) begin
        ramp = t.ramp_step;
        if (ramp <= DRIVE_RAMP_FULL) begin
          scaled    = acc_right;
          acc_right = ACC_W'(scaled * ramp / DRIVE_RAMP_FULL);
          scaled    = acc_left;
          acc_left  = ACC_W'(scaled * ramp / DRIVE_RAMP_FULL);
        end
        split_drive(acc_left, d.left_fwd_duty, d.left_rev_duty);
        split_drive(acc_right, d.right_fwd_duty, d.right_rev_duty);
      end
      owed_duties.push_back(d);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_duty(duty_t got);
      duty_t exp_d;
      if (owed_duties.size() == 0) begin
        errors++;
        $display("%0t: duty word with none expected, expected nothing, actual %h",
                 $time, got);
        return;
      end
      exp_d = owed_duties.pop_front();
      compare_field("left_fwd_duty", 16'(exp_d.left_fwd_duty), 16'(got.left_fwd_duty));
      compare_field("left_rev_duty", 16'(exp_d.left_rev_duty), 16'(got.left_rev_duty));
      compare_field("right_fwd_duty", 16'(exp_d.right_fwd_duty), 16'(got.right_fwd_duty));
      compare_field("right_rev_duty", 16'(exp_d.right_rev_duty), 16'(got.right_rev_duty));
      compare_field("stopped", 16'(exp_d.stopped), 16'(got.stopped));
    endfunction
  endclass

endpackage

FILE: verif/tb_dual_wheel_incremental_pi_pwm.sv
// ============================================================================
// tb_dual_wheel_incremental_pi_pwm
// Self-checking testbench of the dual-wheel incremental PI drive block.
// ============================================================================
// A short directed run hits the field extremes, both direction senses, the
// ramp boundaries and a few stop requests under the reset settings. Then the
// block goes through a series of gain and limit settings, each with a batch
// of random tick words, most of them wheels that roughly track their target
// so the accumulators wander inside their limits rather than sitting on a
// clamp. The last batch lets the stop latch set and carries on beyond it.
// Both channels idle at random, and the receiver now and then holds off for a
// long stretch so the pipeline fills and pushes back on the input.
// ============================================================================
module tb_dual_wheel_incremental_pi_pwm;
  timeunit 1ns;
  timeprecision 1ps;

  import dwpi_pkg::*;
  import dwpi_duty_check_pkg::*;

  localparam int PIPE_LATENCY  = 3;
  localparam int LONG_HOLD_OFF = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int BATCH_WORDS   = 180;

  typedef struct {
    int gain_p;
    int gain_i;
    int drive_max;
    int drive_min;
    int stop_hold;
  } drive_setting_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  dwpi_in_if  in_ch();
  dwpi_out_if out_ch();

  dual_wheel_incremental_pi_pwm u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  wheel_duty_scoreboard sb;

  // Bookkeeping on the stimulus side. The stop counter never clears, so
  // every stop request is counted here to keep the latch clear until the
  // closing batch.
  int unsigned stop_count  = 0;
  int unsigned cur_hold    = STOP_HOLD_RST;
  int unsigned words_sent  = 0;
  bit          source_quiet = 1'b0;
  bit          sink_quiet   = 1'b0;
  int unsigned cycle_count  = 0;

  always #10 clk = ~clk;

  // Watchdog: a hung handshake or a missing duty word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic tick_t make_tick(int lt, int rt, int lc, int ld, int rc, int rd,
                                      int ramp, int req);
    tick_t t;
    t.left_target  = TGT_W'(lt);
    t.right_target = TGT_W'(rt);
    t.left_count   = CNT_W'(lc);
    t.left_dir     = ld[0];
    t.right_count  = CNT_W'(rc);
    t.right_dir    = rd[0];
    t.ramp_step    = RAMP_W'(ramp);
    t.stop_request = req[0];
    return t;
  endfunction

  // Most words model a wheel running near its target, with either a small
  // or a coarse speed error; the rest are fully random fields. Direction
  // bits follow the sign of the modelled speed, with the right wheel's sense
  // inverted.
  function automatic tick_t random_tick();
    tick_t t;
    int    kind;
    int    span;
    int    noise;
    int    l_speed;
    int    r_speed;
    int    ramp_kind;
    kind = $urandom_range(0, 99);
    t.left_target  = TGT_W'($urandom);
    t.right_target = TGT_W'($urandom);
    t.left_count   = CNT_W'($urandom);
    t.left_dir     = 1'($urandom_range(0, 1));
    t.right_count  = CNT_W'($urandom);
    t.right_dir    = 1'($urandom_range(0, 1));
    t.stop_request = 1'b0;
    if (kind < 75) begin
      span = (kind < 55) ? 12 : 1500;
      if (kind < 40) begin
        t.left_target  = TGT_W'(int'($urandom_range(0, 600)) - 300);
        t.right_target = TGT_W'(int'($urandom_range(0, 600)) - 300);
      end
      noise   = $urandom_range(0, 2 * span);
      l_speed = int'($signed(t.left_target)) + noise - span;
      noise   = $urandom_range(0, 2 * span);
      r_speed = int'($signed(t.right_target)) + noise - span;
      t.left_dir    = (l_speed >= 0);
      t.left_count  = CNT_W'((l_speed >= 0) ? l_speed : -l_speed);
      t.right_dir   = (r_speed < 0);
      t.right_count = CNT_W'((r_speed >= 0) ? r_speed : -r_speed);
    end
    // Ramp: scaled steps, the full-scale step itself, and unscaled steps.
    ramp_kind = $urandom_range(0, 9);
    if (ramp_kind < 4)
      t.ramp_step = RAMP_W'($urandom_range(0, DRIVE_RAMP_FULL));
    else if (ramp_kind == 4)
      t.ramp_step = RAMP_W'(DRIVE_RAMP_FULL);
    else
      t.ramp_step = RAMP_W'($urandom_range(DRIVE_RAMP_FULL + 1, 255));
    return t;
  endfunction

  // Offers one tick word after a random gap and holds it until the block
  // takes it. Valid stays high between back-to-back words.
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = source_quiet ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_target  <= t.left_target;
    in_ch.right_target <= t.right_target;
    in_ch.left_count   <= t.left_count;
    in_ch.left_dir     <= t.left_dir;
    in_ch.right_count  <= t.right_count;
    in_ch.right_dir    <= t.right_dir;
    in_ch.ramp_step    <= t.ramp_step;
    in_ch.stop_request <= t.stop_request;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_tick(t);
    if (t.stop_request) stop_count++;
    words_sent++;
    if (words_sent % 32 == 0) source_quiet = ($urandom_range(0, 2) == 0);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Settings change only with the pipeline empty. Every word yields a duty
  // word, so once nothing is owed the block is idle; a few spare cycles are
  // allowed all the same.
  task automatic apply_setting(input drive_setting_t s);
    logic [CFG_IDX_W-1:0] idx[5];
    int                   val[5];
    idx = '{CFG_GAIN_P, CFG_GAIN_I, CFG_DRIVE_MAX, CFG_DRIVE_MIN, CFG_STOP_HOLD};
    val = '{s.gain_p, s.gain_i, s.drive_max, s.drive_min, s.stop_hold};
    wait_drained();
    repeat (PIPE_LATENCY + 1) @(posedge clk);
    foreach (idx[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= CFG_W'(val[i]);
      @(posedge clk);
      sb.set_reg(idx[i], CFG_W'(val[i]));
    end
    cfg_we   <= 1'b0;
    cur_hold = s.stop_hold;
  endtask

  // A batch of random words. Outside the closing batch a stop request is
  // only raised while it cannot reach the hold count.
  task automatic run_batch(input int n_words, input bit closing);
    tick_t t;
    for (int k = 0; k < n_words; k++) begin
      t = random_tick();
      if (closing)
        t.stop_request = 1'($urandom_range(0, 1));
      else
        t.stop_request = (stop_count + 1 < cur_hold) && ($urandom_range(0, 15) == 0);
      send_tick(t);
    end
    in_ch.valid <= 1'b0;
  endtask

  // Result side: a random stall after each duty word, quiet stretches with
  // no stall at all, and now and then one long hold-off while the source
  // keeps offering words.
  initial begin : duty_sink
    duty_t       got;
    int unsigned stall_left;
    int unsigned taken;
    stall_left   = 0;
    taken        = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.left_fwd_duty, out_ch.left_rev_duty, out_ch.right_fwd_duty,
                out_ch.right_rev_duty, out_ch.stopped};
        sb.check_duty(got);
        taken++;
        if (taken % 700 == 250)
          stall_left = LONG_HOLD_OFF;
        else
          stall_left = sink_quiet ? 0 : $urandom_range(0, 18);
        if (taken % 32 == 0) sink_quiet = ($urandom_range(0, 2) == 0);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  initial begin : tick_source
    drive_setting_t s;
    int             hold_pick;
    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_GAIN_P;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.left_target  <= '0;
    in_ch.right_target <= '0;
    in_ch.left_count   <= '0;
    in_ch.left_dir     <= 1'b0;
    in_ch.right_count  <= '0;
    in_ch.right_dir    <= 1'b0;
    in_ch.ramp_step    <= '0;
    in_ch.stop_request <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset settings: clamps at both limits,
    // counts of both senses at full scale, the ramp at zero, one, just
    // under, at and just over full scale, zero error at the field extremes,
    // and two stop requests well short of the hold count.
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 101, 0));
    send_tick(make_tick(1023, 1023, 0, 1, 0, 0, 255, 0));
    send_tick(make_tick(1023, 1023, 0, 1, 0, 0, 100, 0));
    send_tick(make_tick(-1024, -1024, 0, 0, 0, 1, 150, 0));
    send_tick(make_tick(0, 0, 32767, 1, 32767, 0, 255, 0));
    send_tick(make_tick(0, 0, 32767, 0, 32767, 1, 255, 0));
    send_tick(make_tick(-1024, 1023, 32767, 1, 32767, 1, 101, 0));
    send_tick(make_tick(300, -300, 300, 1, 300, 1, 0, 0));
    send_tick(make_tick(300, -300, 290, 1, 310, 1, 50, 0));
    send_tick(make_tick(-500, 500, 480, 0, 520, 0, 99, 0));
    send_tick(make_tick(100, 100, 100, 1, 100, 0, 101, 1));
    send_tick(make_tick(-100, -100, 100, 0, 100, 1, 100, 1));
    send_tick(make_tick(5, -5, 5, 1, 5, 1, 255, 0));
    send_tick(make_tick(1023, -1024, 1023, 1, 1024, 1, 200, 0));
    send_tick(make_tick(0, 0, 16384, 1, 16384, 0, 33, 0));
    send_tick(make_tick(-1, -1, 1, 0, 1, 1, 101, 0));
    send_tick(make_tick(512, -512, 0, 0, 0, 0, 255, 0));
    send_tick(make_tick(0, 0, 0, 1, 0, 1, 1, 0));
    in_ch.valid <= 1'b0;

    // Reset gains with the widest hold, then the gain and limit extremes.
    apply_setting('{973, 3200, 990, -200, 255});
    run_batch(BATCH_WORDS, 1'b0);
    apply_setting('{0, 65535, 1023, -1024, 255});
    run_batch(BATCH_WORDS, 1'b0);
    apply_setting('{65535, 0, 0, 0, 255});
    run_batch(BATCH_WORDS, 1'b0);
    apply_setting('{256, 32, 500, -500, 255});
    run_batch(BATCH_WORDS, 1'b0);
    // Lower limit above the upper one: the upper limit wins.
    apply_setting('{40, 8, 100, 300, 255});
    run_batch(BATCH_WORDS, 1'b0);
    // Shortest holds are written here, but no stop is raised under them.
    apply_setting('{65535, 65535, 1023, -1024, 1});
    run_batch(BATCH_WORDS, 1'b0);
    apply_setting('{12, 3, 1023, -1024, 0});
    run_batch(BATCH_WORDS, 1'b0);
    repeat (2) begin
      s.gain_p    = $urandom_range(0, 2000);
      s.gain_i    = $urandom_range(0, 500);
      s.drive_max = $urandom_range(0, 1023);
      s.drive_min = -int'($urandom_range(0, 1024));
      s.stop_hold = 255;
      apply_setting(s);
      run_batch(BATCH_WORDS, 1'b0);
    end

    // Closing batch: a hold of zero, one, or just past the requests so far,
    // so the latch sets early and the rest of the words run latched.
    hold_pick = $urandom_range(0, 2);
    s = '{973, 3200, 990, -200, 0};
    if (hold_pick == 1)
      s.stop_hold = 1;
    else if (hold_pick == 2)
      s.stop_hold = (stop_count + 30 > 255) ? 255 : stop_count + $urandom_range(1, 30);
    apply_setting(s);
    run_batch(160, 1'b1);

    wait_drained();
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
sv/dwpi_pkg.sv
sv/dwpi_if.sv
sv/dwpi_lane.sv
sv/dwpi_stop.sv
sv/dual_wheel_incremental_pi_pwm.sv
verif/dwpi_duty_check_pkg.sv
verif/tb_dual_wheel_incremental_pi_pwm.sv
